// ===== src/tfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tfa_pkg;

    localparam int BUF_DEPTH_DEF = 64;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] TERM_RESET    = 8'd94;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd300;
    localparam logic [TICK_W-1:0] TICK_MAX      = '1;

    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'd1;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEND
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;      // request taken this cycle
        logic load_first;  // read entry 0 into the output register
        logic load_next;   // read the following entry into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close;       // the pending request closes the frame
        logic last;        // output register holds the final byte
    } status_t;

endpackage

`default_nettype wire

// ===== src/tfa_rx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tfa_rx_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [tfa_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/tfa_frame_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tfa_frame_if;
    logic                        valid;
    logic                        ready;
    logic [tfa_pkg::BYTE_W-1:0]  frame_byte;
    logic [tfa_pkg::LEN_W-1:0]   frame_length;
    logic                        by_timeout;
    logic                        last;

    modport source (output valid, output frame_byte, output frame_length,
                    output by_timeout, output last, input ready);
    modport sink   (input valid, input frame_byte, input frame_length,
                    input by_timeout, input last, output ready);
endinterface

`default_nettype wire

// ===== src/tfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rx_valid,
    output logic             rx_ready,
    output logic             frame_valid,
    input  logic             frame_ready,
    input  tfa_pkg::status_t status,
    output tfa_pkg::cmd_t    cmd
);

    tfa_pkg::state_t state_reg;
    tfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfa_pkg::ST_IDLE:
            begin
                if (rx_valid && status.close)
                begin
                    state_next = tfa_pkg::ST_LOAD;
                end
            end
            tfa_pkg::ST_LOAD:
            begin
                state_next = tfa_pkg::ST_SEND;
            end
            tfa_pkg::ST_SEND:
            begin
                if (frame_ready && status.last)
                begin
                    state_next = tfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rx_ready       = 1'b0;
        frame_valid    = 1'b0;
        cmd.accept     = 1'b0;
        cmd.load_first = 1'b0;
        cmd.load_next  = 1'b0;
        unique case (state_reg)
            tfa_pkg::ST_IDLE:
            begin
                rx_ready   = 1'b1;
                cmd.accept = rx_valid;
            end
            tfa_pkg::ST_LOAD:
            begin
                cmd.load_first = 1'b1;
            end
            tfa_pkg::ST_SEND:
            begin
                frame_valid   = 1'b1;
                // stream the next byte straight behind the one taken
                cmd.load_next = frame_ready && !status.last;
            end
            default:
            begin
                rx_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_close_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && rx_ready && status.close) |=> !rx_ready)
        else $error("request taken after frame close");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_first |=> frame_valid)
        else $error("first frame byte not presented");

    a_stream_on: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready && !status.last) |=> (frame_valid && !rx_ready))
        else $error("frame emission broke off early");
`endif

endmodule

`default_nettype wire

// ===== src/tfa_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfa_dpath #(
    parameter int BUF_DEPTH = tfa_pkg::BUF_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_action,
    input  logic [tfa_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [tfa_pkg::BYTE_W-1:0]  terminator,
    input  logic [tfa_pkg::TICK_W-1:0]  timeout,
    input  tfa_pkg::cmd_t               cmd,
    output tfa_pkg::status_t            status,
    output logic [tfa_pkg::BYTE_W-1:0]  frame_byte,
    output logic [tfa_pkg::LEN_W-1:0]   frame_length,
    output logic                        by_timeout,
    output logic                        last
);

    localparam int FW = $clog2(BUF_DEPTH);
    localparam logic [FW-1:0] MAX_FILL = FW'(BUF_DEPTH - 1);

    logic [tfa_pkg::BYTE_W-1:0] mem [BUF_DEPTH];

    logic [FW-1:0]              fill_reg,  fill_next;
    logic [tfa_pkg::TICK_W-1:0] idle_reg,  idle_next;
    logic [FW-1:0]              len_reg,   len_next;
    logic                       timed_reg, timed_next;
    logic [FW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic                       last_reg,  last_next;
    logic [tfa_pkg::BYTE_W-1:0] byte_reg;

    logic                       is_byte;
    logic                       close_byte;
    logic                       close_timeout;
    logic [tfa_pkg::TICK_W-1:0] idle_inc;
    logic                       store_en;
    logic [tfa_pkg::BYTE_W-1:0] store_data;
    logic [FW-1:0]              fill_after;
    logic                       load;
    logic [FW-1:0]              rd_addr;

    assign is_byte       = (rx_action == tfa_pkg::ACT_BYTE);
    assign idle_inc      = (idle_reg < tfa_pkg::TICK_MAX) ? idle_reg + 1'b1 : idle_reg;
    assign close_byte    = is_byte && (rx_byte == terminator);
    assign close_timeout = !is_byte && (fill_reg != '0) && (idle_inc > timeout);
    assign status.close  = close_byte || close_timeout;
    assign status.last   = last_reg;

    // on a forced flush store a synthetic terminator; drop when full
    assign store_en   = cmd.accept && (is_byte || close_timeout) && (fill_reg < MAX_FILL);
    assign store_data = is_byte ? rx_byte : terminator;
    assign fill_after = store_en ? fill_reg + FW'(1) : fill_reg;

    assign load    = cmd.load_first || cmd.load_next;
    assign rd_addr = cmd.load_next ? rd_ptr_reg + FW'(1) : '0;

    always_comb
    begin
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        len_next    = len_reg;
        timed_next  = timed_reg;
        rd_ptr_next = rd_ptr_reg;
        last_next   = last_reg;
        if (cmd.accept)
        begin
            idle_next = is_byte ? '0 : idle_inc;
            if (status.close)
            begin
                fill_next  = '0;
                len_next   = fill_after;
                timed_next = close_timeout;
            end
            else
            begin
                fill_next = fill_after;
            end
        end
        if (load)
        begin
            rd_ptr_next = rd_addr;
            last_next   = ((rd_addr + FW'(1)) == len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            idle_reg   <= '0;
            len_reg    <= '0;
            timed_reg  <= 1'b0;
            rd_ptr_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            len_reg    <= len_next;
            timed_reg  <= timed_next;
            rd_ptr_reg <= rd_ptr_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[fill_reg] <= store_data;
        end
        if (load)
        begin
            byte_reg <= mem[rd_addr];
        end
    end

    assign frame_byte   = byte_reg;
    assign frame_length = tfa_pkg::LEN_W'(len_reg);
    assign by_timeout   = timed_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_FILL)
        else $error("fill count beyond buffer capacity");

    a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.close) |=> (fill_reg == '0 && len_reg != '0))
        else $error("closed frame left bytes or has no length");

    a_no_read_past: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_next |-> (!last_reg && rd_ptr_reg + FW'(1) < len_reg))
        else $error("read past the end of the frame");
`endif

endmodule

`default_nettype wire

// ===== src/terminated_frame_assembler_timeout.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame assembler: each request on rx is either a received byte or a
// one millisecond tick. Bytes are kept in a frame memory of BUF_DEPTH-1
// usable entries; a byte equal to terminator_char closes the frame, and
// so does a tick once the idle ticks since the last byte exceed
// idle_timeout while bytes are held (a terminator is appended then if
// there is room). A closed frame goes out on frame one byte per cycle
// while frame.ready is high, after the first byte is read from the frame
// memory into the output register; rx is held off from the close until
// the last byte is taken, as the frame memory has a single read port.
// Register 0 is terminator_char (reset 0x5E), register 1 is idle_timeout
// (reset 300); write them only while no frame is being sent.
module terminated_frame_assembler_timeout #(
    parameter int BUF_DEPTH = tfa_pkg::BUF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tfa_rx_if.sink                         rx,
    tfa_frame_if.source                    frame,
    input  logic                           wr_en,
    input  logic [tfa_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [tfa_pkg::CFG_DATA_W-1:0] wr_data
);

    logic [tfa_pkg::BYTE_W-1:0] term_reg;
    logic [tfa_pkg::TICK_W-1:0] timeout_reg;

    tfa_pkg::cmd_t    cmd;
    tfa_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg    <= tfa_pkg::TERM_RESET;
            timeout_reg <= tfa_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tfa_pkg::REG_TERMINATOR: term_reg    <= wr_data[tfa_pkg::BYTE_W-1:0];
                tfa_pkg::REG_TIMEOUT:    timeout_reg <= wr_data[tfa_pkg::TICK_W-1:0];
                default:                 term_reg    <= term_reg;
            endcase
        end
    end

    tfa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx.valid),
        .rx_ready    (rx.ready),
        .frame_valid (frame.valid),
        .frame_ready (frame.ready),
        .status      (status),
        .cmd         (cmd)
    );

    tfa_dpath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_action    (rx.action),
        .rx_byte      (rx.rx_byte),
        .terminator   (term_reg),
        .timeout      (timeout_reg),
        .cmd          (cmd),
        .status       (status),
        .frame_byte   (frame.frame_byte),
        .frame_length (frame.frame_length),
        .by_timeout   (frame.by_timeout),
        .last         (frame.last)
    );

endmodule

`default_nettype wire

// ===== tb/tfa_frame_checker.sv =====
`timescale 1ns / 1ps

module tfa_frame_checker
    import tfa_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tfa_rx_if                     rx,
    tfa_frame_if                  frame,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              timed;
        logic              last;
    } frame_beat_t;

    frame_beat_t       beats_due[$];
    logic [BYTE_W-1:0] held_bytes[BUF_DEPTH];
    int unsigned       held_count;
    logic [TICK_W-1:0] quiet_ticks;
    logic [BYTE_W-1:0] term_char;
    logic [TICK_W-1:0] flush_after;

    function automatic void keep_byte(input logic [BYTE_W-1:0] b);
        if (held_count < BUF_DEPTH - 1)
        begin
            held_bytes[held_count] = b;
            held_count++;
        end
    endfunction

    // queue one beat per held byte, then empty the buffer
    function automatic void close_frame(input logic timed);
        frame_beat_t beat;
        for (int k = 0; k < held_count; k++)
        begin
            beat.data  = held_bytes[k];
            beat.len   = LEN_W'(held_count);
            beat.timed = timed;
            beat.last  = (k + 1 == held_count);
            beats_due.push_back(beat);
        end
        held_count = 0;
    endfunction

    function automatic void assemble(input logic act, input logic [BYTE_W-1:0] b);
        if (act == ACT_BYTE)
        begin
            quiet_ticks = '0;
            keep_byte(b);
            if (b == term_char)
                close_frame(1'b0);
        end
        else
        begin
            if (quiet_ticks != TICK_MAX)
                quiet_ticks++;
            if (held_count > 0 && quiet_ticks > flush_after)
            begin
                keep_byte(term_char);
                close_frame(1'b1);
            end
        end
    endfunction

    function automatic void check_beat(input frame_beat_t got);
        frame_beat_t want;
        if (beats_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected frame byte data=%02h len=%0d timeout=%0b last=%0b",
                         $time, got.data, got.len, got.timed, got.last);
        end
        else
        begin
            want = beats_due.pop_front();
            if (got.data != want.data || got.len != want.len ||
                got.timed != want.timed || got.last != want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: frame byte mismatch: expected data=%02h len=%0d ",
                              "timeout=%0b last=%0b, got data=%02h len=%0d timeout=%0b last=%0b"},
                             $time, want.data, want.len, want.timed, want.last,
                             got.data, got.len, got.timed, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_due.delete();
            held_count  = 0;
            quiet_ticks = '0;
            term_char   = TERM_RESET;
            flush_after = TIMEOUT_RESET;
            mismatches  = 0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                assemble(rx.action, rx.rx_byte);
            if (frame.valid && frame.ready)
                check_beat('{data: frame.frame_byte, len: frame.frame_length,
                             timed: frame.by_timeout, last: frame.last});
            if (wr_en)
            begin
                if (wr_index == REG_TERMINATOR)
                    term_char = wr_data[BYTE_W-1:0];
                else if (wr_index == REG_TIMEOUT)
                    flush_after = wr_data[TICK_W-1:0];
            end
        end
        pending = beats_due.size();
    end

endmodule

// ===== tb/tb_terminated_frame_assembler_timeout.sv =====
`timescale 1ns / 1ps

module tb_terminated_frame_assembler_timeout;

    import tfa_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    mismatches;
    int                    pending;

    logic [BYTE_W-1:0] cur_term;
    logic [TICK_W-1:0] cur_tmo;
    int                requests_sent;
    logic              gaps_off;
    logic              stall_asked;
    logic              stall_served;

    tfa_rx_if    rx_ch ();
    tfa_frame_if frame_ch ();

    terminated_frame_assembler_timeout u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_ch),
        .frame    (frame_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    tfa_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .frame      (frame_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gaps_off || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if (b == cur_term)
            b = ~b;
        return b;
    endfunction

    // called right after a rising edge; returns at the edge that takes the request
    task automatic push_request(input logic act, input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.action  <= act;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_request(ACT_TICK, BYTE_W'($urandom));
    endtask

    task automatic send_plain(input int n);
        for (int i = 0; i < n; i++)
            push_request(ACT_BYTE, plain_byte());
    endtask

    // drop valid and wait until every frame byte is out and the block is idle
    task automatic settle();
        rx_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] term, input logic [TICK_W-1:0] tmo);
        wr_en    <= 1'b1;
        wr_index <= REG_TERMINATOR;
        wr_data  <= CFG_DATA_W'(term);
        @(posedge clk);
        wr_index <= REG_TIMEOUT;
        wr_data  <= CFG_DATA_W'(tmo);
        @(posedge clk);
        wr_en    <= 1'b0;
        cur_term = term;
        cur_tmo  = tmo;
    endtask

    task automatic random_traffic(input int n_items);
        int start;
        int kind;
        int len;
        start = requests_sent;
        while (requests_sent - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 8);
            if (kind < 55)
            begin
                for (int i = 0; i < len; i++)
                begin
                    push_request(ACT_BYTE, plain_byte());
                    // ticks that stay within the timeout must not flush
                    if (cur_tmo != 0 && $urandom_range(0, 5) == 0)
                        send_ticks($urandom_range(1, (cur_tmo > 4) ? 4 : cur_tmo));
                end
                push_request(ACT_BYTE, cur_term);
            end
            else if (kind < 75)
            begin
                send_plain((len == 0) ? 1 : len);
                send_ticks(cur_tmo + 1 + $urandom_range(0, 2));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_request(logic'($urandom_range(0, 1)),
                                 ($urandom_range(0, 3) == 0) ? cur_term : BYTE_W'($urandom));
            end
        end
    endtask

    // frame sink: random ready, with stretches of none, plus one long hold-off
    initial
    begin
        int pick;
        frame_ch.ready <= 1'b0;
        stall_served = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (stall_asked && !stall_served)
            begin
                stall_served = 1'b1;
                frame_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 6)
                begin
                    frame_ch.ready <= 1'b1;
                    repeat ($urandom_range(10, 60)) @(posedge clk);
                end
                else if (pick < 18)
                begin
                    frame_ch.ready <= ($urandom_range(0, 3) != 0);
                    @(posedge clk);
                end
                else
                begin
                    frame_ch.ready <= 1'b0;
                    repeat ($urandom_range(15, 50)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.action  <= ACT_BYTE;
        rx_ch.rx_byte <= '0;
        wr_en         <= 1'b0;
        wr_index      <= REG_TERMINATOR;
        wr_data       <= '0;
        cur_term      = TERM_RESET;
        cur_tmo       = TIMEOUT_RESET;
        requests_sent = 0;
        gaps_off      = 1'b0;
        stall_asked   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: bytes at both extremes, then the terminator
        push_request(ACT_BYTE, 8'h00);
        push_request(ACT_BYTE, 8'hFF);
        push_request(ACT_BYTE, 8'h41);
        push_request(ACT_BYTE, TERM_RESET);
        push_request(ACT_BYTE, TERM_RESET);
        // ticks on an empty buffer do nothing
        send_ticks(3);
        // ticks below the reset timeout keep the frame open
        push_request(ACT_BYTE, 8'h5A);
        send_ticks(3);
        // full buffer: extra bytes dropped, terminator closes without being stored
        send_plain(BUF_DEPTH_DEF + 1);
        push_request(ACT_BYTE, cur_term);
        settle();

        // zero timeout: first tick after a byte flushes
        set_config(8'h00, 16'd0);
        push_request(ACT_BYTE, 8'h00);
        push_request(ACT_BYTE, 8'hAA);
        send_ticks(1);
        // timeout with full buffer: no room for the synthetic terminator
        send_plain(BUF_DEPTH_DEF - 1);
        send_ticks(1);
        settle();

        // largest timeout: ticks never force a flush
        gaps_off = 1'b1;
        set_config(8'hFF, TICK_MAX);
        push_request(ACT_BYTE, 8'h11);
        send_ticks(5);
        settle();
        set_config(8'hFF, 16'd100);
        send_ticks(1);
        push_request(ACT_BYTE, 8'hFF);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            gaps_off = (phase % 3 == 1);
            case (phase)
                0: set_config(BYTE_W'($urandom), 16'd1);
                1: set_config(8'h00, 16'd3);
                2: set_config(8'hFF, TICK_W'($urandom_range(2, 8)));
                3: set_config(BYTE_W'($urandom), 16'd0);
                4: set_config(BYTE_W'($urandom), TICK_W'($urandom_range(1, 6)));
                default: set_config(TERM_RESET, 16'd5);
            endcase
            if (phase == 0)
            begin
                // receiver holds off while the sender keeps offering
                stall_asked = 1'b1;
                send_plain(30);
                push_request(ACT_BYTE, cur_term);
                send_plain(20);
                push_request(ACT_BYTE, cur_term);
            end
            random_traffic(24);
            settle();
        end

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (pending != 0)
            $display("%0d frame bytes never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
